[src/dchk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchk_pkg
// Shared types, constants and pattern tables of the HTTP response dechunker.
// ----------------------------------------------------------------------------
package dchk_pkg;

    localparam int CHUNK_SIZE_BITS = 32;
    localparam int OQ_DEPTH        = 4;

    localparam logic [4:0] HEAD_LEN = 5'd7;
    localparam logic [4:0] TE_LEN   = 5'd26;
    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic [13:0] STATUS_OK_LO = 14'd200;
    localparam logic [13:0] STATUS_OK_HI = 14'd300;

    localparam logic [2:0] SL_LEAD = 3'd0;
    localparam logic [2:0] SL_SIGN = 3'd1;
    localparam logic [2:0] SL_ZERO = 3'd2;
    localparam logic [2:0] SL_XPFX = 3'd3;
    localparam logic [2:0] SL_DIGS = 3'd4;
    localparam logic [2:0] SL_TAIL = 3'd5;

    localparam logic [2:0] TR_FIRST  = 3'd0;
    localparam logic [2:0] TR_SECOND = 3'd1;

    localparam logic [2:0] SC_WAIT = 3'd0;
    localparam logic [2:0] SC_OPEN = 3'd1;
    localparam logic [2:0] SC_LAST = 3'd4;
    localparam logic [2:0] SC_DONE = 3'd5;

    localparam logic [15:0] MAX_BODY_RESET = 16'd4096;
    localparam logic        REG_MAX_BODY   = 1'b0;

    typedef logic [CHUNK_SIZE_BITS-1:0] t_chunk;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [13:0] status_code;
        logic        status_ok;
        logic        parsed;
        logic        last;
    } t_result;

    function automatic logic [7:0] head_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "H";
            5'd1:    ch = "T";
            5'd2:    ch = "T";
            5'd3:    ch = "P";
            5'd4:    ch = "/";
            5'd5:    ch = "1";
            5'd6:    ch = ".";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "t";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "e";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            5'd17:   ch = ":";
            5'd18:   ch = " ";
            5'd19:   ch = "c";
            5'd20:   ch = "h";
            5'd21:   ch = "u";
            5'd22:   ch = "n";
            5'd23:   ch = "k";
            5'd24:   ch = "e";
            5'd25:   ch = "d";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] end_char(input logic [1:0] pos);
        return pos[0] ? 8'h0A : 8'h0D;
    endfunction

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] d;
        if (c >= "0" && c <= "9") begin
            d = 5'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            d = 5'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            d = 5'(c - "A" + 8'd10);
        end else begin
            d = HEX_NONE;
        end
        return d;
    endfunction

    function automatic t_chunk size_add(input t_chunk rem, input logic [3:0] d);
        t_chunk mx;
        t_chunk lim;
        mx  = '1;
        lim = (mx - t_chunk'(d)) >> 4;
        return (rem > lim) ? mx : ((rem << 4) | t_chunk'(d));
    endfunction

endpackage

[src/dchk_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchk_cfg
// APB register file holding the body length limit.
// ----------------------------------------------------------------------------
module dchk_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_max_body
);

    logic [15:0] r_max_body;
    logic        w_sel_max;

    assign w_sel_max  = (paddr[2] == dchk_pkg::REG_MAX_BODY);
    assign pready     = 1'b1;
    assign prdata     = w_sel_max ? {16'd0, r_max_body} : 32'd0;
    assign o_max_body = r_max_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= dchk_pkg::MAX_BODY_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_max) begin
            r_max_body <= pwdata[15:0];
        end
    end

endmodule

[src/dchk_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchk_parser
// Per-byte response scanner: status line, header search, plain or chunked
// body decoding, and the summary on the last byte.
// ----------------------------------------------------------------------------
module dchk_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [15:0]       i_max_body,
    output logic [1:0]        o_res_cnt,
    output dchk_pkg::t_result o_res0,
    output dchk_pkg::t_result o_res1
);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_PLAIN,
        PH_SIZE,
        PH_DATA,
        PH_TRAIL,
        PH_DONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [4:0]       r_match_pos, n_match_pos;
    logic [1:0]       r_end_pos, n_end_pos;
    logic [13:0]      r_status_acc, n_status_acc;
    logic [2:0]       r_status_chars, n_status_chars;
    logic             r_is_chunked, n_is_chunked;
    dchk_pkg::t_chunk r_chunk_rem, n_chunk_rem;
    logic [2:0]       r_sub, n_sub;
    logic [15:0]      r_body_count, n_body_count;
    logic             r_size_neg, n_size_neg;
    logic             r_size_cr, n_size_cr;
    logic             r_end_seen, n_end_seen;

    logic [7:0]        c;
    logic [7:0]        lc;
    logic [4:0]        hex_d;
    logic              is_digit;
    logic              is_ws;
    logic              emit;
    dchk_pkg::t_result body_res;
    dchk_pkg::t_result sum_res;

    assign c        = i_byte;
    assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign hex_d    = dchk_pkg::hex_of(c);
    assign is_digit = (c >= "0" && c <= "9");
    assign is_ws    = (c == " ") || (c >= 8'd9 && c <= 8'd13);

    always_comb begin
        n_phase        = r_phase;
        n_match_pos    = r_match_pos;
        n_end_pos      = r_end_pos;
        n_status_acc   = r_status_acc;
        n_status_chars = r_status_chars;
        n_is_chunked   = r_is_chunked;
        n_chunk_rem    = r_chunk_rem;
        n_sub          = r_sub;
        n_body_count   = r_body_count;
        n_size_neg     = r_size_neg;
        n_size_cr      = r_size_cr;
        n_end_seen     = r_end_seen;
        emit           = 1'b0;

        if (r_phase != PH_SEARCH) begin
            if (r_status_chars == dchk_pkg::SC_WAIT) begin
                if (c == " ") begin
                    n_status_chars = dchk_pkg::SC_OPEN;
                end
            end else if (r_status_chars <= dchk_pkg::SC_LAST) begin
                if (is_digit) begin
                    n_status_acc   = 14'(r_status_acc * 14'd10) + 14'(c[3:0]);
                    n_status_chars = r_status_chars + 3'd1;
                end else begin
                    n_status_chars = dchk_pkg::SC_DONE;
                end
            end
        end

        case (r_phase)
            PH_SEARCH: begin
                if (r_match_pos < dchk_pkg::HEAD_LEN && c == dchk_pkg::head_char(r_match_pos)) begin
                    n_match_pos = r_match_pos + 5'd1;
                end else begin
                    n_match_pos = (c == "H") ? 5'd1 : 5'd0;
                end
                if (n_match_pos >= dchk_pkg::HEAD_LEN) begin
                    n_phase     = PH_HEADER;
                    n_match_pos = 5'd0;
                    n_end_pos   = 2'd0;
                end
            end
            PH_HEADER: begin
                if (!r_is_chunked) begin
                    if (r_match_pos < dchk_pkg::TE_LEN && lc == dchk_pkg::te_char(r_match_pos)) begin
                        n_match_pos = r_match_pos + 5'd1;
                    end else begin
                        n_match_pos = (lc == "t") ? 5'd1 : 5'd0;
                    end
                    if (n_match_pos >= dchk_pkg::TE_LEN) begin
                        n_is_chunked = 1'b1;
                        n_match_pos  = 5'd0;
                    end
                end
                if (c == dchk_pkg::end_char(r_end_pos)) begin
                    if (r_end_pos == 2'd3) begin
                        n_end_seen = 1'b1;
                        n_end_pos  = 2'd0;
                        if (n_is_chunked) begin
                            n_phase     = PH_SIZE;
                            n_sub       = dchk_pkg::SL_LEAD;
                            n_size_neg  = 1'b0;
                            n_size_cr   = 1'b0;
                            n_chunk_rem = '0;
                        end else begin
                            n_phase = PH_PLAIN;
                        end
                    end else begin
                        n_end_pos = r_end_pos + 2'd1;
                    end
                end else begin
                    n_end_pos = (c == 8'h0D) ? 2'd1 : 2'd0;
                end
            end
            PH_PLAIN: begin
                emit = 1'b1;
            end
            PH_SIZE: begin
                if (r_size_cr && c == 8'h0A) begin
                    if (r_size_neg || r_chunk_rem == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_size_cr = (c == 8'h0D);
                    case (r_sub)
                        dchk_pkg::SL_LEAD, dchk_pkg::SL_SIGN: begin
                            if (r_sub == dchk_pkg::SL_LEAD && is_ws) begin
                                n_sub = r_sub;
                            end else if (r_sub == dchk_pkg::SL_LEAD && (c == "+" || c == "-")) begin
                                n_size_neg = (c == "-");
                                n_sub      = dchk_pkg::SL_SIGN;
                            end else if (c == "0") begin
                                n_sub = dchk_pkg::SL_ZERO;
                            end else if (hex_d != dchk_pkg::HEX_NONE) begin
                                n_chunk_rem = dchk_pkg::size_add(r_chunk_rem, hex_d[3:0]);
                                n_sub       = dchk_pkg::SL_DIGS;
                            end else begin
                                n_sub = dchk_pkg::SL_TAIL;
                            end
                        end
                        dchk_pkg::SL_ZERO: begin
                            if (c == "x" || c == "X") begin
                                n_sub = dchk_pkg::SL_XPFX;
                            end else if (hex_d != dchk_pkg::HEX_NONE) begin
                                n_chunk_rem = dchk_pkg::size_add(r_chunk_rem, hex_d[3:0]);
                                n_sub       = dchk_pkg::SL_DIGS;
                            end else begin
                                n_sub = dchk_pkg::SL_TAIL;
                            end
                        end
                        dchk_pkg::SL_XPFX, dchk_pkg::SL_DIGS: begin
                            if (hex_d != dchk_pkg::HEX_NONE) begin
                                n_chunk_rem = dchk_pkg::size_add(r_chunk_rem, hex_d[3:0]);
                                n_sub       = dchk_pkg::SL_DIGS;
                            end else begin
                                n_sub = dchk_pkg::SL_TAIL;
                            end
                        end
                        default: begin
                            n_sub = r_sub;
                        end
                    endcase
                end
            end
            PH_DATA: begin
                emit = 1'b1;
                if (r_chunk_rem != '0) begin
                    n_chunk_rem = r_chunk_rem - dchk_pkg::t_chunk'(1);
                end
                if (n_chunk_rem == '0) begin
                    n_phase = PH_TRAIL;
                    n_sub   = dchk_pkg::TR_FIRST;
                end
            end
            PH_TRAIL: begin
                if (r_sub != dchk_pkg::TR_FIRST) begin
                    n_phase     = PH_SIZE;
                    n_sub       = dchk_pkg::SL_LEAD;
                    n_size_neg  = 1'b0;
                    n_size_cr   = 1'b0;
                    n_chunk_rem = '0;
                end else begin
                    n_sub = dchk_pkg::TR_SECOND;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        emit = emit && (r_body_count < i_max_body);
        if (emit) begin
            n_body_count = r_body_count + 16'd1;
        end

        body_res           = '0;
        body_res.body_byte = c;

        sum_res             = '0;
        sum_res.kind        = 1'b1;
        sum_res.status_code = n_status_acc;
        sum_res.status_ok   = (n_status_acc >= dchk_pkg::STATUS_OK_LO)
                           && (n_status_acc < dchk_pkg::STATUS_OK_HI);
        sum_res.parsed      = (n_status_chars != dchk_pkg::SC_WAIT) && n_end_seen;
        sum_res.last        = 1'b1;

        o_res_cnt = 2'd0;
        o_res0    = body_res;
        o_res1    = sum_res;
        if (i_valid) begin
            if (emit && i_last) begin
                o_res_cnt = 2'd2;
            end else if (emit) begin
                o_res_cnt = 2'd1;
            end else if (i_last) begin
                o_res_cnt = 2'd1;
                o_res0    = sum_res;
            end
        end

        if (i_last) begin
            n_phase        = PH_SEARCH;
            n_match_pos    = 5'd0;
            n_end_pos      = 2'd0;
            n_status_acc   = 14'd0;
            n_status_chars = dchk_pkg::SC_WAIT;
            n_is_chunked   = 1'b0;
            n_chunk_rem    = '0;
            n_sub          = dchk_pkg::SL_LEAD;
            n_body_count   = 16'd0;
            n_size_neg     = 1'b0;
            n_size_cr      = 1'b0;
            n_end_seen     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SEARCH;
            r_match_pos    <= 5'd0;
            r_end_pos      <= 2'd0;
            r_status_acc   <= 14'd0;
            r_status_chars <= dchk_pkg::SC_WAIT;
            r_is_chunked   <= 1'b0;
            r_chunk_rem    <= '0;
            r_sub          <= dchk_pkg::SL_LEAD;
            r_body_count   <= 16'd0;
            r_size_neg     <= 1'b0;
            r_size_cr      <= 1'b0;
            r_end_seen     <= 1'b0;
        end else if (i_valid) begin
            r_phase        <= n_phase;
            r_match_pos    <= n_match_pos;
            r_end_pos      <= n_end_pos;
            r_status_acc   <= n_status_acc;
            r_status_chars <= n_status_chars;
            r_is_chunked   <= n_is_chunked;
            r_chunk_rem    <= n_chunk_rem;
            r_sub          <= n_sub;
            r_body_count   <= n_body_count;
            r_size_neg     <= n_size_neg;
            r_size_cr      <= n_size_cr;
            r_end_seen     <= n_end_seen;
        end
    end

endmodule

[src/dchk_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dchk_outq
// Small result queue that takes up to two results per cycle and hands out
// one beat per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module dchk_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  dchk_pkg::t_result i_res0,
    input  dchk_pkg::t_result i_res1,
    input  logic              i_ready,
    output logic              o_room2,
    output logic              o_valid,
    output dchk_pkg::t_result o_res
);

    localparam int PW = $clog2(dchk_pkg::OQ_DEPTH);
    localparam int CW = $clog2(dchk_pkg::OQ_DEPTH + 1);

    dchk_pkg::t_result r_mem [dchk_pkg::OQ_DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              w_pop;
    logic [PW-1:0]     w_wr_next;

    assign o_valid   = (r_count != '0);
    assign o_res     = r_mem[r_rd_ptr];
    assign o_room2   = (r_count <= CW'(dchk_pkg::OQ_DEPTH - 2));
    assign w_pop     = o_valid && i_ready;
    assign w_wr_next = r_wr_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push_cnt) - CW'(w_pop);
        end
    end

endmodule

[src/http_response_dechunker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_dechunker_core
// HTTP/1.x response scanner with chunked transfer decoding.
// ----------------------------------------------------------------------------
// The block takes one raw response byte per clock and returns body bytes and,
// after the byte marked last, one summary beat (tuser high, tlast high) with
// the status code, the 2xx flag and the parsed flag. Every byte is handled in
// the cycle it is accepted by the scanner's state update, and its results
// enter a four-entry output queue, so the first result appears in the
// following cycle. The input accepts a beat whenever the queue has two free
// entries, which gives one byte per clock while the output side keeps up.
module http_response_dechunker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] body_byte, [21:8] status_code,
                                        // [22] status_ok, [23] parsed
    output logic        m_axis_tuser,   // [0] out_kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              w_accept;
    logic [15:0]       w_max_body;
    logic [1:0]        w_res_cnt;
    dchk_pkg::t_result w_res0, w_res1, w_out;
    logic              w_room2;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = w_room2;

    dchk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_body (w_max_body)
    );

    dchk_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_max_body (w_max_body),
        .o_res_cnt  (w_res_cnt),
        .o_res0     (w_res0),
        .o_res1     (w_res1)
    );

    dchk_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_res_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_ready    (m_axis_tready),
        .o_room2    (w_room2),
        .o_valid    (m_axis_tvalid),
        .o_res      (w_out)
    );

    assign m_axis_tdata = {w_out.parsed, w_out.status_ok, w_out.status_code, w_out.body_byte};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;

endmodule
